// ===== hw/rtl/qmad_pkg.sv =====
// Package: types, reset values and register map of the quadrature mouse decoder.
package qmad_pkg;

  localparam int unsigned CD_W      = 7;
  localparam int unsigned SPEED_W   = 6;
  localparam int unsigned DEB_W     = 8;
  localparam int unsigned DELTA_W   = 8;
  localparam int unsigned PADDR_W   = 5;
  localparam int unsigned PDATA_W   = 32;

  localparam int unsigned COOLDOWN_CAP_DEF  = 75;
  localparam int unsigned COOLDOWN_STEP_DEF = 3;

  localparam logic [DEB_W-1:0]   DEB_LIMIT_RST  = 8'd12;
  localparam logic [DEB_W-1:0]   DEB_COUNT_RST  = DEB_LIMIT_RST + 8'd1;
  localparam logic [SPEED_W-1:0] MOVE_LOW_RST   = 6'd4;
  localparam logic [SPEED_W-1:0] MOVE_MED_RST   = 6'd8;
  localparam logic [SPEED_W-1:0] MOVE_HIGH_RST  = 6'd16;
  localparam logic [CD_W-1:0]    MED_START_RST  = 7'd8;
  localparam logic [CD_W-1:0]    HIGH_START_RST = 7'd16;

  typedef enum logic [2:0] {
    REG_DEBOUNCE_LIMIT = 3'd0,
    REG_MOVE_LOW       = 3'd1,
    REG_MOVE_MED       = 3'd2,
    REG_MOVE_HIGH      = 3'd3,
    REG_MED_START      = 3'd4,
    REG_HIGH_START     = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic tick;
    logic x_edge_one;
    logic x_edge_two;
    logic y_edge_one;
    logic y_edge_two;
    logic button_edge;
    logic x_line_a;
    logic x_line_b;
    logic y_line_a;
    logic y_line_b;
    logic button_level;
  } in_item_t;

  typedef struct packed {
    logic                       pressed;
    logic signed [DELTA_W-1:0]  delta_x;
    logic signed [DELTA_W-1:0]  delta_y;
  } out_item_t;

endpackage

// ===== hw/rtl/quadrature_mouse_accel_debounce_core.sv =====
// Top level: quadrature mouse decoder with button debounce and step acceleration.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+----------------------------------
//  in      | in  | in_valid_i/in_ready_o | in_data_i  (qmad_pkg::in_item_t)
//  out     | out | out_valid_o/out_ready_i | out_data_o (qmad_pkg::out_item_t)
//  cfg     | in  | psel/penable/pwrite   | paddr, pwdata, prdata, pready
//
// One request per cycle when not stalled; an emitted report appears in the cycle
// after acceptance, from the output register. State updates at the accept edge, so
// the next request sees it immediately. A stalled report blocks input only while
// out_ready_i is low. Reset is asynchronous and takes effect at once; no clearing pass.
module quadrature_mouse_accel_debounce_core #(
  parameter int unsigned COOLDOWN_CAP  = qmad_pkg::COOLDOWN_CAP_DEF,
  parameter int unsigned COOLDOWN_STEP = qmad_pkg::COOLDOWN_STEP_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  qmad_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output qmad_pkg::out_item_t               out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [qmad_pkg::PADDR_W-1:0]      paddr,
  input  logic [qmad_pkg::PDATA_W-1:0]      pwdata,
  output logic [qmad_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  localparam int unsigned CdW = qmad_pkg::CD_W;
  localparam logic [CdW:0] CapW  = (CdW+1)'(COOLDOWN_CAP);
  localparam logic [CdW:0] StepW = (CdW+1)'(COOLDOWN_STEP);

  // configuration registers
  logic [qmad_pkg::DEB_W-1:0]   deb_limit_q;
  logic [qmad_pkg::SPEED_W-1:0] move_low_q, move_med_q, move_high_q;
  logic [CdW-1:0]               med_start_q, high_start_q;

  // block state
  logic [qmad_pkg::DEB_W-1:0] deb_cnt_q, deb_cnt_d;
  logic                       btn_q, btn_d;
  logic [CdW-1:0]             cd_x_q, cd_x_d, cd_y_q, cd_y_d;

  logic                 out_valid_q;
  qmad_pkg::out_item_t  out_data_q, out_data_d;

  logic                 in_accept, cfg_wr, emit, changed;
  qmad_pkg::reg_idx_e   reg_idx;
  logic [2:0]           addr_idx;

  assign pready     = 1'b1;
  assign addr_idx   = paddr[4:2];
  assign cfg_wr     = psel && penable && pwrite;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    reg_idx = qmad_pkg::reg_idx_e'(addr_idx);
    prdata  = '0;
    unique case (addr_idx)
      qmad_pkg::REG_DEBOUNCE_LIMIT: prdata = {24'd0, deb_limit_q};
      qmad_pkg::REG_MOVE_LOW:       prdata = {26'd0, move_low_q};
      qmad_pkg::REG_MOVE_MED:       prdata = {26'd0, move_med_q};
      qmad_pkg::REG_MOVE_HIGH:      prdata = {26'd0, move_high_q};
      qmad_pkg::REG_MED_START:      prdata = {25'd0, med_start_q};
      qmad_pkg::REG_HIGH_START:     prdata = {25'd0, high_start_q};
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_limit_q  <= qmad_pkg::DEB_LIMIT_RST;
      move_low_q   <= qmad_pkg::MOVE_LOW_RST;
      move_med_q   <= qmad_pkg::MOVE_MED_RST;
      move_high_q  <= qmad_pkg::MOVE_HIGH_RST;
      med_start_q  <= qmad_pkg::MED_START_RST;
      high_start_q <= qmad_pkg::HIGH_START_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        qmad_pkg::REG_DEBOUNCE_LIMIT: deb_limit_q  <= pwdata[7:0];
        qmad_pkg::REG_MOVE_LOW:       move_low_q   <= pwdata[5:0];
        qmad_pkg::REG_MOVE_MED:       move_med_q   <= pwdata[5:0];
        qmad_pkg::REG_MOVE_HIGH:      move_high_q  <= pwdata[5:0];
        qmad_pkg::REG_MED_START:      med_start_q  <= pwdata[6:0];
        qmad_pkg::REG_HIGH_START:     high_start_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // per-request datapath
  logic [qmad_pkg::DEB_W-1:0]   cnt_inc;
  logic [CdW-1:0]               cdx_dec, cdy_dec;
  logic [qmad_pkg::SPEED_W-1:0] sx, sy;
  logic                         x_move, y_move, x_pos, y_pos;
  logic [CdW:0]                 cdx_sum, cdy_sum;
  logic signed [qmad_pkg::DELTA_W-1:0] dx, dy;

  always_comb begin
    cnt_inc   = deb_cnt_q + 8'd1;
    deb_cnt_d = deb_cnt_q;
    btn_d     = btn_q;
    changed   = 1'b0;
    cdx_dec   = cd_x_q;
    cdy_dec   = cd_y_q;
    if (in_data_i.tick) begin
      if (deb_cnt_q < deb_limit_q) begin
        deb_cnt_d = cnt_inc;
        if (cnt_inc == deb_limit_q) begin
          changed = 1'b1;
          btn_d   = !in_data_i.button_level;
        end
      end
      if (cd_x_q != '0) cdx_dec = cd_x_q - 1'b1;
      if (cd_y_q != '0) cdy_dec = cd_y_q - 1'b1;
    end
    if (in_data_i.button_edge) deb_cnt_d = '0;

    priority if (cdx_dec >= high_start_q) sx = move_high_q;
    else if (cdx_dec >= med_start_q)      sx = move_med_q;
    else                                  sx = move_low_q;
    priority if (cdy_dec >= high_start_q) sy = move_high_q;
    else if (cdy_dec >= med_start_q)      sy = move_med_q;
    else                                  sy = move_low_q;

    // opposite edges on one axis cancel
    x_move = (in_data_i.x_edge_one ^ in_data_i.x_edge_two) && (sx != '0);
    y_move = (in_data_i.y_edge_one ^ in_data_i.y_edge_two) && (sy != '0);
    x_pos  = in_data_i.x_edge_one ? (in_data_i.x_line_a ^ in_data_i.x_line_b)
                                  : !(in_data_i.x_line_a ^ in_data_i.x_line_b);
    y_pos  = in_data_i.y_edge_two ? (in_data_i.y_line_a ^ in_data_i.y_line_b)
                                  : !(in_data_i.y_line_a ^ in_data_i.y_line_b);
    dx = '0;
    dy = '0;
    if (x_move) dx = x_pos ? $signed({2'b00, sx}) : -$signed({2'b00, sx});
    if (y_move) dy = y_pos ? $signed({2'b00, sy}) : -$signed({2'b00, sy});

    emit    = x_move || y_move || changed;
    cdx_sum = {1'b0, cdx_dec} + StepW;
    cdy_sum = {1'b0, cdy_dec} + StepW;
    cd_x_d  = (x_move && cdx_sum < CapW) ? cdx_sum[CdW-1:0] : cdx_dec;
    cd_y_d  = (y_move && cdy_sum < CapW) ? cdy_sum[CdW-1:0] : cdy_dec;

    out_data_d.pressed = btn_d;
    out_data_d.delta_x = dx;
    out_data_d.delta_y = dy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_cnt_q   <= qmad_pkg::DEB_COUNT_RST;
      btn_q       <= 1'b0;
      cd_x_q      <= '0;
      cd_y_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        deb_cnt_q <= deb_cnt_d;
        btn_q     <= btn_d;
        cd_x_q    <= cd_x_d;
        cd_y_q    <= cd_y_d;
      end
      if (in_accept) begin
        out_valid_q <= emit;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && emit) out_data_q <= out_data_d;
  end

  a_cd_below_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cd_x_q} < CapW) && ({1'b0, cd_y_q} < CapW))
    else $error("cooldown reached cap");

  a_edge_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_data_i.button_edge |=> deb_cnt_q == '0)
    else $error("button edge did not clear debounce counter");

  a_report_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !$past(out_valid_q) |-> $past(in_accept))
    else $error("report without request");

  a_idle_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !in_data_i.tick && !in_data_i.button_edge
      && !in_data_i.x_edge_one && !in_data_i.x_edge_two
      && !in_data_i.y_edge_one && !in_data_i.y_edge_two
    |=> $stable(cd_x_q) && $stable(cd_y_q) && $stable(deb_cnt_q) && !out_valid_q)
    else $error("quiet request changed state");

endmodule

// ===== bench/qmad_checker.sv =====
// Checker for the quadrature mouse decoder: tracks register writes, predicts reports, compares.
module qmad_checker #(
  parameter int unsigned COOLDOWN_CAP  = qmad_pkg::COOLDOWN_CAP_DEF,
  parameter int unsigned COOLDOWN_STEP = qmad_pkg::COOLDOWN_STEP_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_o,
  input  qmad_pkg::in_item_t           in_data_i,
  input  logic                         out_valid_o,
  input  logic                         out_ready_i,
  input  qmad_pkg::out_item_t          out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [qmad_pkg::PADDR_W-1:0] paddr,
  input  logic [qmad_pkg::PDATA_W-1:0] pwdata,
  output int                           errors_o,
  output int                           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [qmad_pkg::DEB_W-1:0]   deb_limit;
  logic [qmad_pkg::SPEED_W-1:0] step_low, step_med, step_high;
  logic [qmad_pkg::CD_W-1:0]    med_thr, high_thr;

  logic [qmad_pkg::DEB_W-1:0]   quiet_ticks;
  logic                         pressed_st;
  logic [qmad_pkg::CD_W-1:0]    heat_x, heat_y;

  qmad_pkg::out_item_t report_q[$];
  int                  errs = 0;

  function automatic int step_for(logic [qmad_pkg::CD_W-1:0] heat);
    if (heat >= high_thr) return int'(step_high);
    if (heat >= med_thr) return int'(step_med);
    return int'(step_low);
  endfunction

  function automatic logic [qmad_pkg::CD_W-1:0] heat_up(logic [qmad_pkg::CD_W-1:0] heat);
    if (int'(heat) + int'(COOLDOWN_STEP) < int'(COOLDOWN_CAP))
      return qmad_pkg::CD_W'(int'(heat) + int'(COOLDOWN_STEP));
    return heat;
  endfunction

  task automatic predict_report(qmad_pkg::in_item_t it);
    logic                sampled;
    logic                x_lead, y_lead;
    int                  dx, dy, sx, sy;
    qmad_pkg::out_item_t rep;
    sampled = 1'b0;
    dx = 0;
    dy = 0;
    x_lead = it.x_line_a ^ it.x_line_b;
    y_lead = it.y_line_a ^ it.y_line_b;
    if (it.tick) begin
      if (quiet_ticks < deb_limit) begin
        quiet_ticks = quiet_ticks + 1'b1;
        if (quiet_ticks == deb_limit) begin
          sampled = 1'b1;
          pressed_st = ~it.button_level;
        end
      end
      if (heat_x != 0) heat_x = heat_x - 1'b1;
      if (heat_y != 0) heat_y = heat_y - 1'b1;
    end
    sx = step_for(heat_x);
    sy = step_for(heat_y);
    if (it.x_edge_one) dx += x_lead ? sx : -sx;
    if (it.x_edge_two) dx += x_lead ? -sx : sx;
    if (it.y_edge_one) dy += y_lead ? -sy : sy;
    if (it.y_edge_two) dy += y_lead ? sy : -sy;
    if (it.button_edge) quiet_ticks = '0;
    if (dx != 0 || dy != 0 || sampled) begin
      if (dx != 0) heat_x = heat_up(heat_x);
      if (dy != 0) heat_y = heat_up(heat_y);
      rep.pressed = pressed_st;
      rep.delta_x = qmad_pkg::DELTA_W'(dx);
      rep.delta_y = qmad_pkg::DELTA_W'(dy);
      report_q.push_back(rep);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    qmad_pkg::out_item_t want;
    if (!rst_ni) begin
      deb_limit   = qmad_pkg::DEB_LIMIT_RST;
      step_low    = qmad_pkg::MOVE_LOW_RST;
      step_med    = qmad_pkg::MOVE_MED_RST;
      step_high   = qmad_pkg::MOVE_HIGH_RST;
      med_thr     = qmad_pkg::MED_START_RST;
      high_thr    = qmad_pkg::HIGH_START_RST;
      quiet_ticks = qmad_pkg::DEB_COUNT_RST;
      pressed_st  = 1'b0;
      heat_x      = '0;
      heat_y      = '0;
      report_q.delete();
      pending_o <= 0;
      errors_o  <= errs;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (qmad_pkg::reg_idx_e'(paddr[qmad_pkg::PADDR_W-1:2]))
          qmad_pkg::REG_DEBOUNCE_LIMIT: deb_limit = pwdata[qmad_pkg::DEB_W-1:0];
          qmad_pkg::REG_MOVE_LOW:       step_low  = pwdata[qmad_pkg::SPEED_W-1:0];
          qmad_pkg::REG_MOVE_MED:       step_med  = pwdata[qmad_pkg::SPEED_W-1:0];
          qmad_pkg::REG_MOVE_HIGH:      step_high = pwdata[qmad_pkg::SPEED_W-1:0];
          qmad_pkg::REG_MED_START:      med_thr   = pwdata[qmad_pkg::CD_W-1:0];
          qmad_pkg::REG_HIGH_START:     high_thr  = pwdata[qmad_pkg::CD_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        if (report_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("unexpected report: pressed=%0d dx=%0d dy=%0d",
                     out_data_o.pressed, out_data_o.delta_x, out_data_o.delta_y);
        end else begin
          want = report_q.pop_front();
          if (out_data_o.pressed !== want.pressed || out_data_o.delta_x !== want.delta_x ||
              out_data_o.delta_y !== want.delta_y) begin
            errs++;
            if (errs <= 10)
              $display("mismatch: exp pressed=%0d dx=%0d dy=%0d got pressed=%0d dx=%0d dy=%0d",
                       want.pressed, want.delta_x, want.delta_y,
                       out_data_o.pressed, out_data_o.delta_x, out_data_o.delta_y);
          end
        end
      end
      if (in_valid_i && in_ready_o)
        predict_report(in_data_i);
      pending_o <= report_q.size();
      errors_o  <= errs;
    end
  end

endmodule

// ===== bench/quadrature_mouse_accel_debounce_core_test.sv =====
// Testbench top: clock, reset, request and register stimulus, final verdict.
module quadrature_mouse_accel_debounce_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int       LIMIT_CYCLES = 2000000;
  localparam logic [2:0] UNUSED_REG = 3'd7;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  qmad_pkg::in_item_t           in_data_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  qmad_pkg::out_item_t          out_data_o;
  logic                         psel, penable, pwrite, pready;
  logic [qmad_pkg::PADDR_W-1:0] paddr;
  logic [qmad_pkg::PDATA_W-1:0] pwdata, prdata;

  int errors, pending, cycles;
  logic steady;
  int tick_pct, edge_pct, bedge_pct;
  int cur_limit;

  quadrature_mouse_accel_debounce_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  qmad_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // report sink back-pressure
  initial begin
    int stall;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      stall = steady ? 0 : pick_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  function automatic qmad_pkg::in_item_t random_item();
    qmad_pkg::in_item_t it;
    logic [10:0]        raw;
    raw = 11'($urandom);
    it = raw;
    if ($urandom_range(0, 9) == 0) return it;
    it.tick        = $urandom_range(0, 99) < tick_pct;
    it.x_edge_one  = $urandom_range(0, 99) < edge_pct;
    it.x_edge_two  = $urandom_range(0, 99) < edge_pct;
    it.y_edge_one  = $urandom_range(0, 99) < edge_pct;
    it.y_edge_two  = $urandom_range(0, 99) < edge_pct;
    it.button_edge = $urandom_range(0, 99) < bedge_pct;
    return it;
  endfunction

  task automatic send(qmad_pkg::in_item_t it);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold off requests until every report is back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [qmad_pkg::PADDR_W-1:0] addr, int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(qmad_pkg::reg_idx_e idx, int unsigned value);
    apb_write({idx, 2'b00}, value);
    if (idx == qmad_pkg::REG_DEBOUNCE_LIMIT) cur_limit = value;
  endtask

  task automatic set_regs(int lim, int lo, int md, int hi, int ms, int hs);
    write_reg(qmad_pkg::REG_DEBOUNCE_LIMIT, lim);
    write_reg(qmad_pkg::REG_MOVE_LOW, lo);
    write_reg(qmad_pkg::REG_MOVE_MED, md);
    write_reg(qmad_pkg::REG_MOVE_HIGH, hi);
    write_reg(qmad_pkg::REG_MED_START, ms);
    write_reg(qmad_pkg::REG_HIGH_START, hs);
  endtask

  // button edge, then enough quiet ticks for the level to be sampled (when the limit is nonzero)
  task automatic debounce_run();
    qmad_pkg::in_item_t it;
    it = random_item();
    it.button_edge = 1'b1;
    send(it);
    repeat (cur_limit + 1) begin
      it = random_item();
      it.tick = 1'b1;
      it.button_edge = 1'b0;
      send(it);
    end
  endtask

  // field order: tick, x_edge_one, x_edge_two, y_edge_one, y_edge_two, button_edge, x lines, y lines, button level
  logic [10:0] directed_q[$] = '{
    11'b1_00_00_0_00_00_1, 11'b1_00_00_0_00_00_1,
    11'b0_10_00_0_10_00_1, 11'b0_01_00_0_10_00_1,
    11'b0_00_10_0_00_10_1, 11'b0_00_01_0_00_01_1,
    11'b0_10_00_0_11_00_1, 11'b0_01_00_0_00_00_1,
    11'b0_00_10_0_00_11_1, 11'b0_00_01_0_00_00_1,
    11'b0_11_00_0_10_00_1, 11'b0_00_11_0_00_01_1,
    11'b1_11_11_1_11_11_1, 11'b0_00_00_1_00_00_0,
    11'b0_00_00_0_00_00_0
  };

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    steady      = 1'b0;
    cycles      = 0;
    cur_limit   = qmad_pkg::DEB_LIMIT_RST;
    tick_pct    = 50;
    edge_pct    = 30;
    bedge_pct   = 6;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // raised limit lets the idle counter run up and sample once
    write_reg(qmad_pkg::REG_DEBOUNCE_LIMIT, 15);
    foreach (directed_q[i]) send(directed_q[i]);
    drain();
    write_reg(qmad_pkg::REG_DEBOUNCE_LIMIT, 2);
    repeat (3) send(qmad_pkg::in_item_t'(11'b1_00_00_0_00_00_0));
    repeat (6) send(qmad_pkg::in_item_t'(11'b0_10_00_0_10_00_0));
    drain();

    for (int ph = 1; ph <= 8; ph++) begin
      case (ph)
        1: set_regs(0, 1, 2, 3, 0, 127);
        2: begin
          set_regs(1, 0, 0, 0, 0, 0);
          apb_write({UNUSED_REG, 2'b00}, 32'hFFFF_FFFF);
        end
        3: set_regs(254, 63, 63, 63, 127, 127);
        4: set_regs($urandom_range(1, 20), $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 63), 20, 5);
        default: set_regs($urandom_range(1, 20), $urandom_range(0, 63),
                          $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 40), $urandom_range(0, 80));
      endcase
      steady    = (ph == 6);
      tick_pct  = $urandom_range(20, 80);
      edge_pct  = $urandom_range(15, 50);
      bedge_pct = $urandom_range(2, 12);
      for (int n = 0; n < 140; n++) begin
        if (ph == 5 && n == 70) drain();
        send(random_item());
      end
      debounce_run();
      drain();
    end

    if (errors == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== quadrature_mouse_accel_debounce_core.f =====
hw/rtl/qmad_pkg.sv
hw/rtl/quadrature_mouse_accel_debounce_core.sv
bench/qmad_checker.sv
bench/quadrature_mouse_accel_debounce_core_test.sv
